// ===== rtl/lpht_pkg.sv =====
// shared types and constants of the linear probing hash table
`default_nettype none

package lpht_pkg;

    localparam int KEY_W          = 16;
    localparam int PAYLOAD_PORT_W = 64;
    localparam int SLOT_W         = 5;
    localparam int IN_TDATA_W     = 80;
    localparam int OUT_TDATA_W    = 72;

    // home slot reduction: key bits taken per cycle
    localparam int HASH_STEPS     = 4;
    localparam int HASH_CYCLES    = KEY_W / HASH_STEPS;
    localparam int HASH_CNT_W     = $clog2(HASH_CYCLES);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        RES_INSERTED  = 2'd0,
        RES_FOUND     = 2'd1,
        RES_NOT_FOUND = 2'd2,
        RES_FULL      = 2'd3
    } res_code_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } eng_state_t;

    typedef struct packed
    {
        res_code_t                   code;
        logic [PAYLOAD_PORT_W-1:0]   payload;
        logic [SLOT_W-1:0]           slot;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/lpht_hash.sv =====
// home slot unit: key modulo table size, a few key bits per cycle
`default_nettype none

module lpht_hash #(
    parameter int TABLE_SIZE = 20
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [lpht_pkg::KEY_W-1:0]       key,
    output logic                                  done,
    output logic [$clog2(TABLE_SIZE)-1:0]         home
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int KW    = lpht_pkg::KEY_W;
    localparam int CNT_W = lpht_pkg::HASH_CNT_W;
    localparam logic [IDX_W:0] TSZ = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lpht_pkg::HASH_CYCLES - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [KW-1:0]        ksh_reg, ksh_next;
    logic [IDX_W-1:0]     rem_step;
    logic [KW-1:0]        ksh_step;

    // restoring remainder, msb first
    always_comb
    begin
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] r;
        logic [KW-1:0]    k;
        r = rem_reg;
        k = ksh_reg;
        for (int j = 0; j < lpht_pkg::HASH_STEPS; j++)
        begin
            t = {r, k[KW-1]};
            k = {k[KW-2:0], 1'b0};
            if (t >= TSZ)
            begin
                t = t - TSZ;
            end
            r = t[IDX_W-1:0];
        end
        rem_step = r;
        ksh_step = k;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        ksh_next  = ksh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            ksh_next  = key;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            ksh_next = ksh_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        ksh_reg <= ksh_next;
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/lpht_engine.sv =====
// probe sequencer with the slot memory
`default_nettype none

module lpht_engine #(
    parameter int TABLE_SIZE    = 20,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   item_valid,
    input  wire lpht_pkg::op_t                          op,
    input  wire logic [lpht_pkg::KEY_W-1:0]             key,
    input  wire logic [lpht_pkg::PAYLOAD_PORT_W-1:0]    payload,
    output logic                                        ready,
    output logic                                        res_valid,
    input  wire logic                                   res_ready,
    output lpht_pkg::result_t                           res
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int KW     = lpht_pkg::KEY_W;
    localparam int PW     = PAYLOAD_WIDTH;
    localparam int PPW    = lpht_pkg::PAYLOAD_PORT_W;
    localparam int SW     = lpht_pkg::SLOT_W;
    localparam int WORD_W = 1 + KW + PW;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

    // slot word: used flag, key, payload
    logic [WORD_W-1:0] mem [TABLE_SIZE];
    logic [WORD_W-1:0] rd_word_reg;

    lpht_pkg::eng_state_t state_reg, state_next;
    lpht_pkg::op_t        op_reg, op_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [PW-1:0]        pay_reg, pay_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     probe_reg, probe_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    lpht_pkg::result_t    res_reg, res_next;

    logic                 hash_start;
    logic                 hash_done;
    logic [IDX_W-1:0]     hash_home;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_W-1:0]    wr_data;

    logic                 slot_used;
    logic                 key_match;
    logic                 last_probe;
    logic                 finish;
    logic [IDX_W-1:0]     pos_inc;

    lpht_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .home  (hash_home)
    );

    assign slot_used  = rd_word_reg[WORD_W-1];
    assign key_match  = (rd_word_reg[PW +: KW] == key_reg);
    assign last_probe = (probe_reg == LAST_SLOT);
    assign pos_inc    = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign finish     = !slot_used || last_probe
                        || (op_reg == lpht_pkg::OP_SEARCH && key_match);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            lpht_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = lpht_pkg::ST_HASH;
                end
            end
            lpht_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = lpht_pkg::ST_PROBE;
                end
            end
            lpht_pkg::ST_PROBE:
            begin
                if (finish)
                begin
                    state_next = lpht_pkg::ST_DONE;
                end
            end
            lpht_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        ready      = 1'b0;
        hash_start = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = pos_inc;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = '0;
        res_valid  = 1'b0;
        case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            lpht_pkg::ST_IDLE:
            begin
                ready      = 1'b1;
                hash_start = item_valid;
            end
            lpht_pkg::ST_HASH:
            begin
                rd_en   = hash_done;
                rd_addr = hash_home;
            end
            lpht_pkg::ST_PROBE:
            begin
                rd_en = !finish;
                if (op_reg == lpht_pkg::OP_INSERT && !slot_used)
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, key_reg, pay_reg};
                end
            end
            lpht_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        op_next    = op_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        pos_next   = pos_reg;
        probe_next = probe_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            lpht_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next  = op;
                    key_next = key;
                    pay_next = payload[PW-1:0];
                end
            end
            lpht_pkg::ST_HASH:
            begin
                if (hash_done)
                begin
                    pos_next   = hash_home;
                    probe_next = '0;
                end
            end
            lpht_pkg::ST_PROBE:
            begin
                res_next.payload = '0;
                res_next.slot    = '0;
                if (!slot_used)
                begin
                    if (op_reg == lpht_pkg::OP_INSERT)
                    begin
                        res_next.code = lpht_pkg::RES_INSERTED;
                        res_next.slot = SW'(pos_reg);
                    end
                    else
                    begin
                        res_next.code = lpht_pkg::RES_NOT_FOUND;
                    end
                end
                else if (op_reg == lpht_pkg::OP_SEARCH && key_match)
                begin
                    res_next.code    = lpht_pkg::RES_FOUND;
                    res_next.payload = PPW'(rd_word_reg[PW-1:0]);
                    res_next.slot    = SW'(pos_reg);
                end
                else if (op_reg == lpht_pkg::OP_INSERT)
                begin
                    res_next.code = lpht_pkg::RES_FULL;
                end
                else
                begin
                    res_next.code = lpht_pkg::RES_NOT_FOUND;
                end
                if (!finish)
                begin
                    pos_next   = pos_inc;
                    probe_next = probe_reg + 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pos_reg   <= '0;
            probe_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pos_reg   <= pos_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        pay_reg <= pay_next;
        res_reg <= res_next;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// top level of the linear probing hash table with its stream ports
`default_nettype none

// channel   direction  tuser            tdata (lowest bits first)
// s_axis    in         opcode [0]       key [15:0], payload [79:16]
// m_axis    out        result_code[1:0] payload_out [63:0], slot_index [68:64], zero pad
//
// after reset a clearing pass writes every slot empty, and no transaction is
// taken on s_axis meanwhile
// one transaction at a time: the home slot unit reduces the 16 key bits, then
// the slots are probed in order from the home slot through the single read
// port of the slot memory, 1 to TABLE_SIZE slots per transaction
// a finished result sits in the output register, so a new transaction can be
// taken while m_axis is stalled; the sequencer holds the next result until
// that register frees up

module linear_probe_hash_table #(
    parameter int TABLE_SIZE    = 20,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [lpht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key, payload
    input  wire logic [0:0]                          s_axis_tuser,  // opcode
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [lpht_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,  // payload_out, slot_index, pad
    output logic [1:0]                               m_axis_tuser   // result_code
);

    localparam int KW  = lpht_pkg::KEY_W;
    localparam int PPW = lpht_pkg::PAYLOAD_PORT_W;
    localparam int SW  = lpht_pkg::SLOT_W;
    localparam int PAD = lpht_pkg::OUT_TDATA_W - PPW - SW;

    logic                 eng_ready;
    logic                 eng_res_valid;
    logic                 eng_res_ready;
    lpht_pkg::result_t    eng_res;
    lpht_pkg::op_t        in_op;

    logic                 out_valid_reg, out_valid_next;
    lpht_pkg::result_t    out_res_reg, out_res_next;

    assign in_op = lpht_pkg::op_t'(s_axis_tuser[0]);

    lpht_engine #(
        .TABLE_SIZE    (TABLE_SIZE),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .op         (in_op),
        .key        (s_axis_tdata[KW-1:0]),
        .payload    (s_axis_tdata[KW +: PPW]),
        .ready      (eng_ready),
        .res_valid  (eng_res_valid),
        .res_ready  (eng_res_ready),
        .res        (eng_res)
    );

    assign s_axis_tready = eng_ready;

    // output register takes a result when empty or emptied in the same cycle
    assign eng_res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = eng_res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.code;
    assign m_axis_tdata  = {{PAD{1'b0}}, out_res_reg.slot, out_res_reg.payload};

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking stream testbench of the linear probing hash table
import lpht_pkg::*;

// software copy of the slot table, with the results still owed by the block
class slot_table_tracker;
    int TABLE_SIZE;
    int PAYLOAD_WIDTH;
    bit used_slot[];
    logic [KEY_W-1:0] slot_keys[];
    logic [PAYLOAD_PORT_W-1:0] slot_data[];
    result_t pending_results[$];
    int mismatch_count;

    function new(int table_size, int payload_width);
        TABLE_SIZE = table_size;
        PAYLOAD_WIDTH = payload_width;
        used_slot = new[table_size];
        slot_keys = new[table_size];
        slot_data = new[table_size];
        foreach (used_slot[i])
        begin
            used_slot[i] = 1'b0;
        end
        mismatch_count = 0;
    endfunction

    function int occupancy();
        int n;
        n = 0;
        foreach (used_slot[i])
        begin
            if (used_slot[i])
                n++;
        end
        return n;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // walks the probe chain from the home slot and, on an insert, updates the table copy
    function result_t lookup_slot(op_t op, logic [KEY_W-1:0] key,
                                  logic [PAYLOAD_PORT_W-1:0] payload);
        result_t res;
        logic [PAYLOAD_PORT_W-1:0] mask;
        int pos;
        mask = (PAYLOAD_WIDTH >= PAYLOAD_PORT_W) ? '1
             : ((64'd1 << PAYLOAD_WIDTH) - 64'd1);
        pos = int'(key) % TABLE_SIZE;
        res.payload = '0;
        res.slot = '0;
        if (op == OP_INSERT)
        begin
            res.code = RES_FULL;
            for (int probe = 0; probe < TABLE_SIZE; probe++)
            begin
                if (!used_slot[pos])
                begin
                    used_slot[pos] = 1'b1;
                    slot_keys[pos] = key;
                    slot_data[pos] = payload & mask;
                    res.code = RES_INSERTED;
                    res.slot = SLOT_W'(pos);
                    break;
                end
                pos = (pos + 1 == TABLE_SIZE) ? 0 : pos + 1;
            end
        end
        else
        begin
            res.code = RES_NOT_FOUND;
            for (int probe = 0; probe < TABLE_SIZE; probe++)
            begin
                if (!used_slot[pos])
                    break;
                if (slot_keys[pos] == key)
                begin
                    res.code = RES_FOUND;
                    res.payload = slot_data[pos];
                    res.slot = SLOT_W'(pos);
                    break;
                end
                pos = (pos + 1 == TABLE_SIZE) ? 0 : pos + 1;
            end
        end
        return res;
    endfunction

    function void note_request(op_t op, logic [KEY_W-1:0] key,
                               logic [PAYLOAD_PORT_W-1:0] payload);
        pending_results.push_back(lookup_slot(op, key, payload));
    endfunction

    function void check_response(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: code %0d payload %h slot %0d",
                         got.code, got.payload, got.slot);
            return;
        end
        want = pending_results.pop_front();
        if (got.code !== want.code || got.payload !== want.payload
            || got.slot !== want.slot)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result mismatch: expected code %0d payload %h slot %0d,",
                         want.code, want.payload, want.slot,
                         " got code %0d payload %h slot %0d",
                         got.code, got.payload, got.slot);
        end
    endfunction
endclass

module testbench;

    localparam int TABLE_SIZE     = 20;
    localparam int PAYLOAD_WIDTH  = 64;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int RX_HOLD_CYCLES = 300;   // long output stall, fills the block
    localparam int IDLE_LIMIT     = 5000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES   = 40;    // beyond the worst item latency

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata;   // key [15:0], payload [79:16]
    logic [0:0]                s_axis_tuser;   // opcode
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;   // payload_out [63:0], slot_index [68:64], pad
    logic [1:0]                m_axis_tuser;   // result_code

    slot_table_tracker tracker;
    bit  hold_request;
    int  idle_cycles;
    logic [KEY_W-1:0] key_pool[16];

    linear_probe_hash_table #(
        .TABLE_SIZE    (TABLE_SIZE),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock, period 10
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one transaction from the falling edge, hold it until taken
    task automatic send_request(op_t op, logic [KEY_W-1:0] key,
                                logic [PAYLOAD_PORT_W-1:0] payload);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {payload, key};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_request(op, key, payload);
    endtask

    // sender gap with valid low, skipped when n is not positive
    task automatic sender_gap(int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop offering and wait for every owed result
    task automatic wait_for_drain();
        sender_gap(1);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PAYLOAD_PORT_W-1:0] random_payload();
        return {$urandom, $urandom};
    endfunction

    // mostly keys from a pool sharing a few home slots, so chains grow long
    function automatic logic [KEY_W-1:0] random_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, 15)];
        return KEY_W'($urandom_range(0, 65535));
    endfunction

    // random stream in bursts, with the long output stall and a full drain
    task automatic run_random(int count);
        int   sent;
        int   burst;
        op_t  op;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                // inserts are rare so the table fills part way through
                op = ($urandom_range(0, 19) == 0) ? OP_INSERT : OP_SEARCH;
                send_request(op, random_key(), random_payload());
                sent++;
                if (sent == 600)
                    hold_request = 1'b1;
                if (sent == 1100)
                    wait_for_drain();
            end
            // about a quarter of the bursts run straight into the next one
            if ($urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 12));
        end
    endtask

    // receiver: own stall pattern in segments, plus one long hold off
    initial
    begin
        int seg_left;
        int seg_mode;
        int hold_left;
        m_axis_tready = 1'b0;
        seg_left  = 0;
        seg_mode  = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = RX_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(1, 40);
                end
                seg_left--;
                case (seg_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= seg_left[0];
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result monitor on the rising edge
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.code    = res_code_t'(m_axis_tuser);
            got.payload = m_axis_tdata[PAYLOAD_PORT_W-1:0];
            got.slot    = m_axis_tdata[PAYLOAD_PORT_W +: SLOT_W];
            tracker.check_response(got);
        end
    end

    // watchdog: counts cycles in which neither side moves a transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("linear_probe_hash_table: mismatch");
            $finish;
        end
    end

    initial
    begin
        tracker = new(TABLE_SIZE, PAYLOAD_WIDTH);
        hold_request  = 1'b0;
        idle_cycles   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;

        // pool keys share home slots 0, 1, 5, 18 and 19, plus both key extremes
        key_pool[0] = '0;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 16; i++)
        begin
            case (i % 5)
                0: key_pool[i] = KEY_W'(0  + 20 * $urandom_range(0, 3275));
                1: key_pool[i] = KEY_W'(1  + 20 * $urandom_range(0, 3275));
                2: key_pool[i] = KEY_W'(5  + 20 * $urandom_range(0, 3275));
                3: key_pool[i] = KEY_W'(18 + 20 * $urandom_range(0, 3275));
                default: key_pool[i] = KEY_W'(19 + 20 * $urandom_range(0, 3275));
            endcase
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, collision and wrap
        send_request(OP_SEARCH, 16'd0,     64'd0);              // search on empty table
        send_request(OP_INSERT, 16'd0,     64'd0);              // lowest key and payload
        send_request(OP_INSERT, 16'hFFFF,  '1);                 // highest key and payload
        send_request(OP_INSERT, 16'd0,     random_payload());   // duplicate goes further along
        send_request(OP_INSERT, 16'd20,    random_payload());   // same home slot as key 0
        send_request(OP_SEARCH, 16'd0,     random_payload());   // returns the first copy
        send_request(OP_SEARCH, 16'd20,    64'd0);
        send_request(OP_SEARCH, 16'hFFFF,  '1);
        send_request(OP_SEARCH, 16'd40,    64'd0);              // chain ends at an empty slot
        send_request(OP_INSERT, 16'd19,    random_payload());   // last slot
        send_request(OP_INSERT, 16'd39,    random_payload());   // wraps past the last slot
        send_request(OP_SEARCH, 16'd39,    64'd0);
        send_request(OP_SEARCH, 16'd19,    '1);
        wait_for_drain();

        run_random(RANDOM_ITEMS);

        // directed close: top up to a full table, then insert and search on it
        while (tracker.occupancy() < TABLE_SIZE)
            send_request(OP_INSERT, random_key(), random_payload());
        send_request(OP_INSERT, 16'd7,     random_payload());   // table full
        send_request(OP_INSERT, 16'hFFFF,  '1);                 // table full, extremes
        send_request(OP_SEARCH, 16'd12345, 64'd0);              // no empty slot to stop at
        send_request(OP_SEARCH, 16'd39,    64'd0);
        sender_gap(1);

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("linear_probe_hash_table: match");
        else
            $display("linear_probe_hash_table: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lpht_pkg.sv
rtl/lpht_hash.sv
rtl/lpht_engine.sv
rtl/linear_probe_hash_table.sv
verif/testbench.sv
